// ----- hw/rtl/trt_pkg.sv -----
// Package with the types, codes and constants of the tensor residency tracker.
package trt_pkg;

	localparam int NumTensors = 256;
	localparam int IdW        = 8;
	localparam int EpochW     = 32;
	localparam int BytesW     = 48;
	localparam int StatW      = 64;
	localparam int NumStats   = 13;

	typedef enum logic [3:0] {
		CMD_REGISTER   = 4'd0,
		CMD_PREDICT    = 4'd1,
		CMD_END_LAYER  = 4'd2,
		CMD_RESIDENT   = 4'd3,
		CMD_EVICTED    = 4'd4,
		CMD_PREFETCHED = 4'd5,
		CMD_MISS       = 4'd6,
		CMD_ENFORCE    = 4'd7,
		CMD_QUERY      = 4'd8
	} cmd_t;

	localparam logic [2:0] ST_UNKNOWN     = 3'd0;
	localparam logic [2:0] ST_REQUESTED   = 3'd1;
	localparam logic [2:0] ST_PREFETCHING = 3'd2;
	localparam logic [2:0] ST_RESIDENT    = 3'd3;
	localparam logic [2:0] ST_EVICTABLE   = 3'd4;
	localparam logic [2:0] ST_EVICTED     = 3'd5;

	localparam logic [3:0] C_PREDICTIONS   = 4'd0;
	localparam logic [3:0] C_REQUESTS      = 4'd1;
	localparam logic [3:0] C_HITS          = 4'd2;
	localparam logic [3:0] C_BYTES_REQ     = 4'd3;
	localparam logic [3:0] C_PROMOTIONS    = 4'd4;
	localparam logic [3:0] C_BYTES_PROM    = 4'd5;
	localparam logic [3:0] C_EVICTIONS     = 4'd9;
	localparam logic [3:0] C_BYTES_EVICT   = 4'd10;
	localparam logic [3:0] C_PREFETCH_HITS = 4'd11;
	localparam logic [3:0] C_MISSES        = 4'd12;

	localparam logic [1:0] REG_ENABLE = 2'd0;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic              known;
		logic [2:0]        state;
		logic [1:0]        tier;
		logic [BytesW-1:0] bytes;
		logic [EpochW-1:0] last;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_SUM_RD,
		S_SUM,
		S_SEL_RD,
		S_SEL,
		S_EVICT,
		S_OUT_RD,
		S_OUT,
		S_CLEAR
	} fsm_t;

	typedef struct packed {
		logic [3:0]        command;
		logic [IdW-1:0]    tensor_id;
		logic [1:0]        tier;
		logic [BytesW-1:0] byte_count;
		logic [3:0]        stat_index;
	} req_t;

	typedef struct packed {
		logic [2:0]       entry_state_out;
		logic [1:0]       entry_tier_out;
		logic [StatW-1:0] stat_value;
	} rsp_t;

endpackage

// ----- hw/rtl/trt_stream_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface trt_req_if;
	logic          valid;
	logic          ready;
	trt_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface trt_rsp_if;
	logic          valid;
	logic          ready;
	trt_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tensor_residency_tracker_core.sv -----
// Top level of the tensor residency tracker: entry memory, counters and command sequencer.
// Each command is taken into a sequencer that reads its entry from a single-port table
// memory with a registered read, updates it and writes it back. Enforce sums the tier in one
// pass over all 256 entries, then runs one selection pass per evicted entry, and ends when the
// tier is within budget or the candidates run out. After reset a clearing pass writes every
// entry back to its reset value, during which no command is taken; APB writes are taken always.
module tensor_residency_tracker_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	trt_req_if.sink           req,
	trt_rsp_if.source         rsp
);

	localparam int IdW = trt_pkg::IdW;
	localparam int BW  = trt_pkg::BytesW;
	localparam int EW  = trt_pkg::EpochW;
	localparam int SW  = trt_pkg::StatW;

	// Configuration registers.
	logic [2:0]    enable_q;
	logic [BW-1:0] budget_q [1:3];
	logic [1:0]    reg_idx;
	logic          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			budget_q[1] <= '0;
			budget_q[2] <= '0;
			budget_q[3] <= '0;
		end else if (cfg_wr) begin
			if (reg_idx == trt_pkg::REG_ENABLE) begin
				enable_q <= pwdata[2:0];
			end else begin
				budget_q[reg_idx] <= pwdata[BW-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == trt_pkg::REG_ENABLE) begin
			prdata[2:0] = enable_q;
		end else begin
			prdata[BW-1:0] = budget_q[reg_idx];
		end
	end

	// Entry memory: one port, registered read.
	trt_pkg::entry_t mem [trt_pkg::NumTensors];
	trt_pkg::entry_t rd_q;
	logic            mem_we;
	logic [IdW-1:0]  mem_addr;
	trt_pkg::entry_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		rd_q <= mem[mem_addr];
	end

	// Sequencer state.
	trt_pkg::fsm_t   st_q, st_d;
	trt_pkg::req_t   cmd_q;
	logic [IdW:0]    ptr_q, ptr_d;
	logic [SW-1:0]   stat_q [trt_pkg::NumStats];
	logic [EW-1:0]   epoch_q;
	logic [BW+8:0]   used_q, freed_q;
	logic            found_q, found_d;
	logic [IdW-1:0]  best_q, best_d;
	logic [EW-1:0]   best_last_q, best_last_d;
	trt_pkg::rsp_t   out_q;
	logic            out_v_q;
	logic            cand;
	logic [IdW-1:0]  ptr_lo;
	logic            sum_done_ok;

	assign ptr_lo    = ptr_q[IdW-1:0];
	assign req.ready = (st_q == trt_pkg::S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	assign cand = rd_q.known && (rd_q.tier == cmd_q.tier)
		&& ((rd_q.state == trt_pkg::ST_RESIDENT) || (rd_q.state == trt_pkg::ST_EVICTABLE));

	// Usage of the tier within its budget after the sum pass.
	assign sum_done_ok = (used_q <= {9'd0, budget_q[cmd_q.tier]});

	// Next state and memory port control.
	always_comb begin
		st_d        = st_q;
		ptr_d       = ptr_q;
		mem_we      = 1'b0;
		mem_addr    = cmd_q.tensor_id;
		mem_wd      = rd_q;
		found_d     = found_q;
		best_d      = best_q;
		best_last_d = best_last_q;
		case (st_q)
			trt_pkg::S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = ptr_lo;
				mem_wd   = '0;
				ptr_d    = ptr_q + 1'b1;
				if (ptr_q[IdW]) begin
					st_d = trt_pkg::S_IDLE;
				end
			end
			trt_pkg::S_IDLE: begin
				mem_addr = req.payload.tensor_id;
				if (req.valid && req.ready) begin
					st_d = trt_pkg::S_READ;
				end
			end
			trt_pkg::S_READ: st_d = trt_pkg::S_EXEC;
			trt_pkg::S_EXEC: begin
				st_d = trt_pkg::S_OUT_RD;
				case (cmd_q.command)
					trt_pkg::CMD_REGISTER: begin
						mem_we = 1'b1;
						mem_wd.known = 1'b1;
						if (rd_q.bytes == '0) mem_wd.bytes = cmd_q.byte_count;
					end
					trt_pkg::CMD_PREDICT: begin
						mem_we = 1'b1;
						mem_wd.known = 1'b1;
						if (rd_q.state == trt_pkg::ST_RESIDENT) begin
							mem_wd.last = epoch_q;
						end else if (rd_q.state == trt_pkg::ST_UNKNOWN
							|| rd_q.state == trt_pkg::ST_EVICTED) begin
							mem_wd.state = trt_pkg::ST_REQUESTED;
						end
					end
					trt_pkg::CMD_RESIDENT: begin
						mem_we = 1'b1;
						mem_wd.known = 1'b1;
						mem_wd.state = trt_pkg::ST_RESIDENT;
						mem_wd.tier  = cmd_q.tier;
						mem_wd.bytes = cmd_q.byte_count;
						mem_wd.last  = epoch_q;
					end
					trt_pkg::CMD_EVICTED: begin
						if (rd_q.known && rd_q.state != trt_pkg::ST_EVICTED) begin
							mem_we = 1'b1;
							mem_wd.state = trt_pkg::ST_EVICTED;
							mem_wd.tier  = 2'd0;
						end
					end
					trt_pkg::CMD_PREFETCHED: begin
						mem_we = 1'b1;
						mem_wd.known = 1'b1;
						mem_wd.state = trt_pkg::ST_PREFETCHING;
					end
					trt_pkg::CMD_MISS: begin
						mem_we = 1'b1;
						mem_wd.known = 1'b1;
						mem_wd.state = trt_pkg::ST_UNKNOWN;
					end
					trt_pkg::CMD_ENFORCE: begin
						if (cmd_q.tier != 2'd0 && enable_q[cmd_q.tier - 2'd1]) begin
							st_d  = trt_pkg::S_SUM_RD;
							ptr_d = '0;
						end
					end
					default: ;
				endcase
			end
			// Sum pass: address ptr, data arrives in the next cycle.
			trt_pkg::S_SUM_RD: begin
				mem_addr = ptr_lo;
				ptr_d    = ptr_q + 1'b1;
				st_d     = trt_pkg::S_SUM;
			end
			trt_pkg::S_SUM: begin
				mem_addr = ptr_lo;
				if (ptr_q[IdW]) begin
					st_d  = trt_pkg::S_SEL_RD;
					ptr_d = '0;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			// A tier within its budget ends the command before any selection.
			trt_pkg::S_SEL_RD: begin
				mem_addr = ptr_lo;
				ptr_d    = ptr_q + 1'b1;
				found_d  = 1'b0;
				st_d     = sum_done_ok ? trt_pkg::S_OUT_RD : trt_pkg::S_SEL;
			end
			trt_pkg::S_SEL: begin
				mem_addr = ptr_lo;
				if (cand && (!found_q || rd_q.last < best_last_q)) begin
					found_d     = 1'b1;
					best_d      = ptr_lo - 1'b1;
					best_last_d = rd_q.last;
				end
				if (ptr_q[IdW]) begin
					mem_addr = best_d;
					st_d = found_d ? trt_pkg::S_EVICT : trt_pkg::S_OUT_RD;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			trt_pkg::S_EVICT: begin
				mem_addr     = best_q;
				mem_we       = 1'b1;
				mem_wd.state = trt_pkg::ST_EVICTED;
				mem_wd.tier  = 2'd0;
				ptr_d        = '0;
				if (freed_q + {9'd0, rd_q.bytes} + {9'd0, budget_q[cmd_q.tier]} >= used_q) begin
					st_d = trt_pkg::S_OUT_RD;
				end else begin
					st_d = trt_pkg::S_SEL_RD;
				end
			end
			trt_pkg::S_OUT_RD: st_d = trt_pkg::S_OUT;
			trt_pkg::S_OUT: st_d = trt_pkg::S_IDLE;
			default: st_d = trt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= trt_pkg::S_CLEAR;
			ptr_q   <= '0;
			out_v_q <= 1'b0;
			epoch_q <= EW'(1);
			for (int k = 0; k < trt_pkg::NumStats; k++) stat_q[k] <= '0;
		end else begin
			st_q  <= st_d;
			ptr_q <= ptr_d;
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			if (st_q == trt_pkg::S_OUT) out_v_q <= 1'b1;
			// Counter updates per command.
			if (st_q == trt_pkg::S_EXEC) begin
				case (cmd_q.command)
					trt_pkg::CMD_PREDICT: begin
						stat_q[trt_pkg::C_REQUESTS] <= stat_q[trt_pkg::C_REQUESTS] + 1'b1;
						if (rd_q.state == trt_pkg::ST_RESIDENT) begin
							stat_q[trt_pkg::C_HITS] <= stat_q[trt_pkg::C_HITS] + 1'b1;
						end else if (rd_q.state == trt_pkg::ST_UNKNOWN
							|| rd_q.state == trt_pkg::ST_EVICTED) begin
							stat_q[trt_pkg::C_BYTES_REQ] <= stat_q[trt_pkg::C_BYTES_REQ]
								+ SW'(rd_q.bytes);
						end
					end
					trt_pkg::CMD_END_LAYER: begin
						stat_q[trt_pkg::C_PREDICTIONS] <= stat_q[trt_pkg::C_PREDICTIONS] + 1'b1;
						epoch_q <= (epoch_q == '1) ? EW'(1) : epoch_q + 1'b1;
					end
					trt_pkg::CMD_RESIDENT: begin
						stat_q[trt_pkg::C_PROMOTIONS] <= stat_q[trt_pkg::C_PROMOTIONS] + 1'b1;
						stat_q[trt_pkg::C_BYTES_PROM] <= stat_q[trt_pkg::C_BYTES_PROM]
							+ SW'(cmd_q.byte_count);
						if (cmd_q.tier != 2'd0) begin
							stat_q[4'd5 + 4'(cmd_q.tier)] <= stat_q[4'd5 + 4'(cmd_q.tier)]
								+ SW'(cmd_q.byte_count);
						end
					end
					trt_pkg::CMD_EVICTED: begin
						if (rd_q.known && rd_q.state != trt_pkg::ST_EVICTED) begin
							if (rd_q.tier != 2'd0) begin
								stat_q[4'd5 + 4'(rd_q.tier)] <=
									(stat_q[4'd5 + 4'(rd_q.tier)] > SW'(rd_q.bytes))
									? stat_q[4'd5 + 4'(rd_q.tier)] - SW'(rd_q.bytes) : '0;
							end
							stat_q[trt_pkg::C_EVICTIONS] <= stat_q[trt_pkg::C_EVICTIONS] + 1'b1;
							stat_q[trt_pkg::C_BYTES_EVICT] <= stat_q[trt_pkg::C_BYTES_EVICT]
								+ SW'(rd_q.bytes);
						end
					end
					trt_pkg::CMD_PREFETCHED: begin
						stat_q[trt_pkg::C_PREFETCH_HITS] <=
							stat_q[trt_pkg::C_PREFETCH_HITS] + 1'b1;
					end
					trt_pkg::CMD_MISS: begin
						stat_q[trt_pkg::C_MISSES] <= stat_q[trt_pkg::C_MISSES] + 1'b1;
						stat_q[trt_pkg::C_BYTES_REQ] <= stat_q[trt_pkg::C_BYTES_REQ]
							+ SW'(cmd_q.byte_count);
					end
					default: ;
				endcase
			end
			// An eviction by enforce: the tier is the command's tier.
			if (st_q == trt_pkg::S_EVICT) begin
				stat_q[4'd5 + 4'(cmd_q.tier)] <=
					(stat_q[4'd5 + 4'(cmd_q.tier)] > SW'(rd_q.bytes))
					? stat_q[4'd5 + 4'(cmd_q.tier)] - SW'(rd_q.bytes) : '0;
				stat_q[trt_pkg::C_EVICTIONS] <= stat_q[trt_pkg::C_EVICTIONS] + 1'b1;
				stat_q[trt_pkg::C_BYTES_EVICT] <= stat_q[trt_pkg::C_BYTES_EVICT]
					+ SW'(rd_q.bytes);
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		found_q     <= found_d;
		best_q      <= best_d;
		best_last_q <= best_last_d;
		if (req.valid && req.ready) cmd_q <= req.payload;
		if (st_q == trt_pkg::S_SUM_RD) begin
			used_q  <= '0;
			freed_q <= '0;
		end else if (st_q == trt_pkg::S_SUM) begin
			if (rd_q.known && rd_q.tier == cmd_q.tier && rd_q.state == trt_pkg::ST_RESIDENT) begin
				used_q <= used_q + {9'd0, rd_q.bytes};
			end
		end
		if (st_q == trt_pkg::S_EVICT) freed_q <= freed_q + {9'd0, rd_q.bytes};
		// Result: entry after the command, and the counter on a query.
		if (st_q == trt_pkg::S_OUT) begin
			out_q.entry_state_out <= rd_q.state;
			out_q.entry_tier_out  <= rd_q.tier;
			out_q.stat_value      <= (cmd_q.command == trt_pkg::CMD_QUERY
				&& cmd_q.stat_index < 4'(trt_pkg::NumStats)) ? stat_q[cmd_q.stat_index] : '0;
		end
	end

endmodule

// ----- tb/tensor_residency_tracker_core_test.sv -----
// Self-checking testbench of the tensor residency tracker core with a behavioral predictor.
module tensor_residency_tracker_core_test;

	localparam int WatchdogLimit = 200000;
	localparam int DrainCycles   = 40;
	localparam int NumTensors    = trt_pkg::NumTensors;
	localparam int NumStats      = trt_pkg::NumStats;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	trt_req_if req_ch ();
	trt_rsp_if rsp_ch ();

	tensor_residency_tracker_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// Register indexes of the configuration port.
	localparam int RegEnable = 0;
	localparam int RegVram   = 1;
	localparam int RegRam    = 2;
	localparam int RegNvme   = 3;

	localparam logic [1:0] TIER_NONE = 2'd0;
	localparam logic [1:0] TIER_VRAM = 2'd1;
	localparam logic [1:0] TIER_RAM  = 2'd2;
	localparam logic [1:0] TIER_NVME = 2'd3;
	localparam logic [3:0] CMD_UNUSED = 4'd15;
	localparam logic [47:0] MAX_BYTES = 48'hFFFF_FFFF_FFFF;

	// Shadow copy of the tensor table, counters and budgets.
	logic        tab_known [NumTensors];
	logic [2:0]  tab_state [NumTensors];
	logic [1:0]  tab_tier  [NumTensors];
	logic [47:0] tab_size  [NumTensors];
	logic [31:0] tab_last  [NumTensors];
	logic [31:0] cur_epoch;
	logic [63:0] counters [NumStats];
	logic [2:0]  budget_on;
	logic [47:0] tier_limit [4];

	trt_pkg::rsp_t expected_rsp [$];
	bit   failed;
	bit   steady;
	int   quiet_cycles;

	// Typed expectation that travels with the command being offered.
	bit            offer_has_exp;
	trt_pkg::rsp_t offer_exp;

	typedef struct {
		trt_pkg::req_t cmd;
		bit            has_exp;
		trt_pkg::rsp_t exp;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic void drain_tier(logic [1:0] t, logic [47:0] b);
		int k;
		k = int'(t) + 5;
		if (t != TIER_NONE)
			counters[k] = (counters[k] > 64'(b)) ? counters[k] - 64'(b) : 64'd0;
	endfunction

	function automatic void evict_tensor(int i);
		drain_tier(tab_tier[i], tab_size[i]);
		tab_state[i] = trt_pkg::ST_EVICTED;
		tab_tier[i] = TIER_NONE;
		counters[trt_pkg::C_EVICTIONS] += 64'd1;
		counters[trt_pkg::C_BYTES_EVICT] += 64'(tab_size[i]);
	endfunction

	// Budget enforcement: evict the oldest entries of the tier until usage fits.
	function automatic void enforce_tier(logic [1:0] t);
		logic [63:0] used;
		logic [63:0] freed;
		logic [63:0] limit;
		int best;
		used = '0;
		freed = '0;
		if (t == TIER_NONE || !budget_on[t-1])
			return;
		limit = 64'(tier_limit[t]);
		for (int i = 0; i < NumTensors; i++)
			if (tab_known[i] && tab_tier[i] == t && tab_state[i] == trt_pkg::ST_RESIDENT)
				used += 64'(tab_size[i]);
		if (used <= limit)
			return;
		for (int n = 0; n < NumTensors; n++) begin
			best = -1;
			for (int i = 0; i < NumTensors; i++) begin
				if (!tab_known[i] || tab_tier[i] != t)
					continue;
				if (tab_state[i] != trt_pkg::ST_RESIDENT
					&& tab_state[i] != trt_pkg::ST_EVICTABLE)
					continue;
				if (best < 0 || tab_last[i] < tab_last[best])
					best = i;
			end
			if (best < 0)
				return;
			freed += 64'(tab_size[best]);
			evict_tensor(best);
			if (freed + limit >= used)
				return;
		end
	endfunction

	// Applies one command to the shadow table and returns the result it gives.
	function automatic trt_pkg::rsp_t track_command(trt_pkg::req_t r);
		trt_pkg::rsp_t o;
		int i;
		i = int'(r.tensor_id);
		o.stat_value = '0;
		case (r.command)
			trt_pkg::CMD_REGISTER: begin
				tab_known[i] = 1'b1;
				if (tab_size[i] == '0)
					tab_size[i] = r.byte_count;
			end
			trt_pkg::CMD_PREDICT: begin
				tab_known[i] = 1'b1;
				counters[trt_pkg::C_REQUESTS] += 64'd1;
				if (tab_state[i] == trt_pkg::ST_RESIDENT) begin
					counters[trt_pkg::C_HITS] += 64'd1;
					tab_last[i] = cur_epoch;
				end else if (tab_state[i] == trt_pkg::ST_UNKNOWN
					|| tab_state[i] == trt_pkg::ST_EVICTED) begin
					tab_state[i] = trt_pkg::ST_REQUESTED;
					counters[trt_pkg::C_BYTES_REQ] += 64'(tab_size[i]);
				end
			end
			trt_pkg::CMD_END_LAYER: begin
				counters[trt_pkg::C_PREDICTIONS] += 64'd1;
				cur_epoch = cur_epoch + 32'd1;
				if (cur_epoch == '0)
					cur_epoch = 32'd1;
			end
			trt_pkg::CMD_RESIDENT: begin
				tab_known[i] = 1'b1;
				tab_state[i] = trt_pkg::ST_RESIDENT;
				tab_tier[i] = r.tier;
				tab_size[i] = r.byte_count;
				tab_last[i] = cur_epoch;
				counters[trt_pkg::C_PROMOTIONS] += 64'd1;
				counters[trt_pkg::C_BYTES_PROM] += 64'(r.byte_count);
				if (r.tier != TIER_NONE)
					counters[int'(r.tier) + 5] += 64'(r.byte_count);
			end
			trt_pkg::CMD_EVICTED: begin
				if (tab_known[i] && tab_state[i] != trt_pkg::ST_EVICTED)
					evict_tensor(i);
			end
			trt_pkg::CMD_PREFETCHED: begin
				tab_known[i] = 1'b1;
				tab_state[i] = trt_pkg::ST_PREFETCHING;
				counters[trt_pkg::C_PREFETCH_HITS] += 64'd1;
			end
			trt_pkg::CMD_MISS: begin
				tab_known[i] = 1'b1;
				tab_state[i] = trt_pkg::ST_UNKNOWN;
				counters[trt_pkg::C_MISSES] += 64'd1;
				counters[trt_pkg::C_BYTES_REQ] += 64'(r.byte_count);
			end
			trt_pkg::CMD_ENFORCE: enforce_tier(r.tier);
			trt_pkg::CMD_QUERY: begin
				if (r.stat_index < NumStats)
					o.stat_value = counters[r.stat_index];
			end
			default: ;
		endcase
		o.entry_state_out = tab_state[i];
		o.entry_tier_out = tab_tier[i];
		return o;
	endfunction

	function automatic logic [47:0] rand_bytes48();
		return 48'({$urandom, $urandom} & 64'(MAX_BYTES));
	endfunction

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predict on every command transfer and check every result transfer.
	always @(posedge clk) begin
		trt_pkg::rsp_t got;
		trt_pkg::rsp_t want;
		trt_pkg::rsp_t pred;
		if (req_ch.valid && req_ch.ready) begin
			pred = track_command(req_ch.payload);
			expected_rsp.insert(expected_rsp.size(), offer_has_exp ? offer_exp : pred);
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (expected_rsp.size() == 0) begin
				$display("%0t: result with nothing expected: state %0d tier %0d value %0h",
					$time, got.entry_state_out, got.entry_tier_out, got.stat_value);
				failed = 1'b1;
			end else begin
				want = expected_rsp.pop_front();
				if (got.entry_state_out !== want.entry_state_out) begin
					$display("%0t: entry_state_out expected %0d actual %0d", $time,
						want.entry_state_out, got.entry_state_out);
					failed = 1'b1;
				end
				if (got.entry_tier_out !== want.entry_tier_out) begin
					$display("%0t: entry_tier_out expected %0d actual %0d", $time,
						want.entry_tier_out, got.entry_tier_out);
					failed = 1'b1;
				end
				if (got.stat_value !== want.stat_value) begin
					$display("%0t: stat_value expected %0h actual %0h", $time,
						want.stat_value, got.stat_value);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side back-pressure in random bursts, held off while steady is set.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			if (steady) begin
				rsp_ch.ready = 1'b1;
				@(negedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				rsp_ch.ready = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	task automatic write_reg(int idx, logic [63:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 5'(8 * idx);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == RegEnable)
			budget_on = value[2:0];
		else
			tier_limit[idx] = value[47:0];
	endtask

	// Offers one command and waits for its transfer; called at a falling edge.
	task automatic send_command(trt_pkg::req_t r, bit has_exp, trt_pkg::rsp_t exp);
		if (!steady && $urandom_range(0, 5) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.payload = r;
		offer_has_exp = has_exp;
		offer_exp = exp;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		offer_has_exp = 1'b0;
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic add_row(logic [3:0] c, logic [7:0] id, logic [1:0] t, logic [47:0] b,
		logic [3:0] si, bit chk, logic [2:0] st, logic [1:0] tr, logic [63:0] v);
		dir_row_t row;
		row.cmd = '{command: c, tensor_id: id, tier: t, byte_count: b, stat_index: si};
		row.has_exp = chk;
		row.exp = '{entry_state_out: st, entry_tier_out: tr, stat_value: v};
		dir_rows.insert(dir_rows.size(), row);
	endtask

	function automatic trt_pkg::req_t random_command();
		trt_pkg::req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)      r.command = trt_pkg::CMD_REGISTER;
		else if (pick < 25) r.command = trt_pkg::CMD_PREDICT;
		else if (pick < 33) r.command = trt_pkg::CMD_END_LAYER;
		else if (pick < 51) r.command = trt_pkg::CMD_RESIDENT;
		else if (pick < 59) r.command = trt_pkg::CMD_EVICTED;
		else if (pick < 65) r.command = trt_pkg::CMD_PREFETCHED;
		else if (pick < 71) r.command = trt_pkg::CMD_MISS;
		else if (pick < 79) r.command = trt_pkg::CMD_ENFORCE;
		else if (pick < 97) r.command = trt_pkg::CMD_QUERY;
		else                r.command = 4'($urandom_range(9, 15));
		// Most traffic lands on a small pool so that entries get reused.
		r.tensor_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 15));
		r.tier = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: r.byte_count = rand_bytes48();
			1: r.byte_count = MAX_BYTES;
			2: r.byte_count = '0;
			default: r.byte_count = 48'($urandom_range(1, 1000));
		endcase
		r.stat_index = 4'($urandom_range(0, 15));
		return r;
	endfunction

	initial begin
		dir_row_t row;
		trt_pkg::rsp_t none;
		none = '0;
		failed = 1'b0;
		steady = 1'b0;
		quiet_cycles = 0;
		offer_has_exp = 1'b0;
		offer_exp = '0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		for (int i = 0; i < NumTensors; i++) begin
			tab_known[i] = 1'b0;
			tab_state[i] = trt_pkg::ST_UNKNOWN;
			tab_tier[i] = TIER_NONE;
			tab_size[i] = '0;
			tab_last[i] = '0;
		end
		for (int i = 0; i < NumStats; i++)
			counters[i] = '0;
		cur_epoch = 32'd1;
		budget_on = '0;
		for (int i = 0; i < 4; i++)
			tier_limit[i] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		write_reg(RegEnable, 64'd5);
		write_reg(RegVram, 64'd250);
		write_reg(RegRam, 64'd0);
		write_reg(RegNvme, 64'd0);

		// Directed part: reset values, extremes, each command and the corner cases.
		add_row(trt_pkg::CMD_QUERY, 8'd0, TIER_NONE, '0, trt_pkg::C_PREDICTIONS, 1'b1,
			trt_pkg::ST_UNKNOWN, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_QUERY, 8'd0, TIER_NONE, '0, 4'd15, 1'b1,
			trt_pkg::ST_UNKNOWN, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_REGISTER, 8'd255, TIER_NONE, MAX_BYTES, '0, 1'b1,
			trt_pkg::ST_UNKNOWN, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_PREDICT, 8'd255, TIER_NONE, '0, '0, 1'b1,
			trt_pkg::ST_REQUESTED, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_QUERY, 8'd255, TIER_NONE, '0, trt_pkg::C_BYTES_REQ, 1'b1,
			trt_pkg::ST_REQUESTED, TIER_NONE, 64'(MAX_BYTES));
		add_row(trt_pkg::CMD_RESIDENT, 8'd1, TIER_VRAM, 48'd100, '0, 1'b1,
			trt_pkg::ST_RESIDENT, TIER_VRAM, 64'd0);
		add_row(trt_pkg::CMD_RESIDENT, 8'd2, TIER_VRAM, 48'd200, '0, 1'b1,
			trt_pkg::ST_RESIDENT, TIER_VRAM, 64'd0);
		add_row(trt_pkg::CMD_END_LAYER, 8'd0, TIER_NONE, '0, '0, 1'b1,
			trt_pkg::ST_UNKNOWN, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_PREDICT, 8'd2, TIER_NONE, '0, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_RESIDENT, 8'd3, TIER_VRAM, 48'd50, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_ENFORCE, 8'd1, TIER_VRAM, '0, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_QUERY, 8'd2, TIER_NONE, '0, 4'd6, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_EVICTED, 8'd1, TIER_NONE, '0, '0, 1'b1,
			trt_pkg::ST_EVICTED, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_EVICTED, 8'd7, TIER_NONE, '0, '0, 1'b1,
			trt_pkg::ST_UNKNOWN, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_PREFETCHED, 8'd4, TIER_NONE, '0, '0, 1'b1,
			trt_pkg::ST_PREFETCHING, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_MISS, 8'd4, TIER_NONE, 48'd77, '0, 1'b1,
			trt_pkg::ST_UNKNOWN, TIER_NONE, 64'd0);
		add_row(trt_pkg::CMD_ENFORCE, 8'd2, TIER_NONE, '0, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_RESIDENT, 8'd6, TIER_RAM, 48'd9, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_ENFORCE, 8'd6, TIER_RAM, '0, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_RESIDENT, 8'd5, TIER_NVME, MAX_BYTES, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_ENFORCE, 8'd5, TIER_NVME, '0, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_QUERY, 8'd5, TIER_NONE, '0, trt_pkg::C_BYTES_EVICT, 1'b0,
			'0, '0, 64'd0);
		add_row(CMD_UNUSED, 8'd2, TIER_NVME, MAX_BYTES, 4'd15, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_REGISTER, 8'd2, TIER_NONE, 48'd5, '0, 1'b0, '0, '0, 64'd0);
		add_row(trt_pkg::CMD_QUERY, 8'd255, TIER_NONE, '0, trt_pkg::C_MISSES, 1'b0,
			'0, '0, 64'd0);

		@(negedge clk);
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			send_command(row.cmd, row.has_exp, row.exp);
		end
		// Hold off until every directed result is back.
		wait_idle();

		// Random phases, each under its own budget setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(RegEnable, 64'd7);
					write_reg(RegVram, 64'd0);
					write_reg(RegRam, 64'(MAX_BYTES));
					write_reg(RegNvme, 64'd500);
				end
				1: begin
					write_reg(RegEnable, 64'd0);
				end
				5: begin
					write_reg(RegEnable, 64'd7);
					write_reg(RegVram, 64'(MAX_BYTES));
					write_reg(RegRam, 64'd1500);
					write_reg(RegNvme, 64'd0);
					steady = 1'b1;
				end
				default: begin
					write_reg(RegEnable, 64'($urandom_range(0, 7)));
					write_reg(RegVram, 64'($urandom_range(0, 3000)));
					write_reg(RegRam, 64'($urandom_range(0, 3000)));
					write_reg(RegNvme, ($urandom_range(0, 3) == 0) ? 64'(rand_bytes48())
						: 64'($urandom_range(0, 3000)));
				end
			endcase
			@(negedge clk);
			for (int n = 0; n < 240; n++)
				send_command(random_command(), 1'b0, none);
			wait_idle();
		end

		if (expected_rsp.size() == 0 && !failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
